// File: rtl/core/ascx_pkg.sv
`default_nettype none
package ascx_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [3:0]  HDR_LEN       = 4'd8;
    localparam logic [7:0]  LINE_LEN_RST  = 8'd64;
    localparam logic [15:0] CRC_FACTOR    = 16'h1081;
    localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CH_QUOTE      = 8'h22;

    // queued work kinds
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_ERR   = 2'd2;

    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_error;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h48;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h34;
            3'd5:    c = 8'h38;
            3'd6:    c = 8'h2D;
            3'd7:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'd0, n};
        end else begin
            c = 8'h37 + {4'd0, n};
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [3:0] n);
        logic [3:0] t;
        t = n ^ crc[3:0];
        return (crc >> 4) ^ ({12'd0, t} * CRC_FACTOR);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ascx_front.sv
`default_nettype none
module ascx_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  ascx_pkg::t_in    i_data,
    input  wire              i_q_full,
    output logic             o_stall,
    output ascx_pkg::t_push  o_push
);
    import ascx_pkg::*;

    logic [3:0] r_hdr_idx, n_hdr_idx;
    logic       r_err, n_err;
    logic       w_acc;

    assign o_stall = i_q_full;
    assign w_acc   = i_valid && !i_q_full;

    always_comb begin
        n_hdr_idx     = r_hdr_idx;
        n_err         = r_err;
        o_push.valid  = 1'b0;
        o_push.cmd    = '{kind: CMD_BYTE, data: i_data.data_byte};
        if (w_acc) begin
            if (i_data.action == ACT_CLOSE) begin
                o_push.valid    = 1'b1;
                o_push.cmd.kind = r_err ? CMD_ERR : CMD_CLOSE;
                n_hdr_idx       = 4'd0;
                n_err           = 1'b0;
            end else if (r_err) begin
                o_push.valid    = 1'b1;
                o_push.cmd.kind = CMD_ERR;
            end else if (r_hdr_idx < HDR_LEN) begin
                if (i_data.data_byte == hdr_char(r_hdr_idx[2:0])) begin
                    n_hdr_idx = r_hdr_idx + 4'd1;
                end else begin
                    o_push.valid    = 1'b1;
                    o_push.cmd.kind = CMD_ERR;
                    n_err           = 1'b1;
                end
            end else begin
                o_push.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= 4'd0;
            r_err     <= 1'b0;
        end else begin
            r_hdr_idx <= n_hdr_idx;
            r_err     <= n_err;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ascx_fifo.sv
`default_nettype none
module ascx_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  ascx_pkg::t_push  i_push,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output ascx_pkg::t_cmd   o_head
);
    import ascx_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ascx_back.sv
`default_nettype none
module ascx_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [7:0]        i_cfg_wdata,
    input  wire              i_q_empty,
    input  ascx_pkg::t_cmd   i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_stall,
    output ascx_pkg::t_out   o_data
);
    import ascx_pkg::*;

    logic [7:0]  r_len;
    logic [7:0]  r_col, n_col;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_snap, n_snap;
    logic [2:0]  r_ph, n_ph;      // nibbles done, then quote / final newline for close
    logic        r_nl, n_nl;      // newline owed after last nibble
    logic        r_ov, n_ov;
    t_out        r_out, n_out;

    logic        w_adv;
    logic [15:0] w_src;
    logic [3:0]  w_nib;
    logic [7:0]  w_col_inc;
    logic        w_wrap;

    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign w_adv   = !i_q_empty && (!r_ov || !i_stall);

    always_comb begin
        w_src = (r_ph == 3'd0) ? r_crc : r_snap;
        if (i_head.kind == CMD_CLOSE) begin
            case (r_ph[1:0])
                2'd0:    w_nib = w_src[3:0];
                2'd1:    w_nib = w_src[7:4];
                2'd2:    w_nib = w_src[11:8];
                2'd3:    w_nib = w_src[15:12];
                default: w_nib = w_src[3:0];
            endcase
        end else begin
            w_nib = r_ph[0] ? i_head.data[7:4] : i_head.data[3:0];
        end
        w_col_inc = r_col + 8'd1;
        w_wrap    = (w_col_inc >= r_len);
    end

    always_comb begin
        n_ph   = r_ph;
        n_nl   = r_nl;
        n_col  = r_col;
        n_crc  = r_crc;
        n_snap = r_snap;
        n_out  = r_out;
        n_ov   = r_ov && i_stall;
        o_pop  = 1'b0;
        if (w_adv) begin
            n_ov = 1'b1;
            case (i_head.kind)
                CMD_BYTE, CMD_CLOSE: begin
                    if (r_nl) begin
                        n_out = '{out_char: CH_NEWLINE, is_error: 1'b0,
                                  last: (i_head.kind == CMD_BYTE) && (r_ph == 3'd2)};
                        n_nl  = 1'b0;
                        if (i_head.kind == CMD_BYTE && r_ph == 3'd2) begin
                            o_pop = 1'b1;
                            n_ph  = 3'd0;
                        end
                    end else if (i_head.kind == CMD_CLOSE && r_ph == 3'd4) begin
                        n_out = '{out_char: CH_QUOTE, is_error: 1'b0, last: 1'b0};
                        n_ph  = 3'd5;
                    end else if (i_head.kind == CMD_CLOSE && r_ph >= 3'd5) begin
                        n_out = '{out_char: CH_NEWLINE, is_error: 1'b0, last: 1'b1};
                        o_pop = 1'b1;
                        n_ph  = 3'd0;
                        n_col = 8'd0;
                        n_crc = 16'd0;
                    end else begin
                        n_out = '{out_char: hex_char(w_nib), is_error: 1'b0,
                                  last: (i_head.kind == CMD_BYTE) && (r_ph == 3'd1) && !w_wrap};
                        n_crc = crc_step(r_crc, w_nib);
                        if (r_ph == 3'd0) begin
                            n_snap = r_crc;
                        end
                        if (w_wrap) begin
                            n_nl  = 1'b1;
                            n_col = 8'd0;
                        end else begin
                            n_col = w_col_inc;
                        end
                        if (i_head.kind == CMD_BYTE && r_ph == 3'd1 && !w_wrap) begin
                            o_pop = 1'b1;
                            n_ph  = 3'd0;
                        end else begin
                            n_ph = r_ph + 3'd1;
                        end
                    end
                end
                default: begin
                    n_out = '{out_char: 8'd0, is_error: 1'b1, last: 1'b1};
                    o_pop = 1'b1;
                    n_ph  = 3'd0;
                    n_nl  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_snap <= n_snap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LINE_LEN_RST;
            r_col <= 8'd0;
            r_crc <= 16'd0;
            r_ph  <= 3'd0;
            r_nl  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_col <= n_col;
            r_crc <= n_crc;
            r_ph  <= n_ph;
            r_nl  <= n_nl;
            r_ov  <= n_ov;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/calculator_asc_hex_encoder.sv
// Byte stream to hex text encoder with header check and nibble CRC trailer.
// Input channel i_valid/o_stall carries beats of {action, data_byte}; output
// channel o_valid/i_stall carries beats of {out_char, is_error, last}.
// The first eight data bytes must spell the expected header; they are absorbed
// with no output. A mismatch yields one error beat and every later data beat
// yields an error beat until a close. After the header each byte gives two hex
// characters, low nibble first, with a newline after every line_length chars.
// A close gives four CRC characters, a quote and a newline (one error beat if
// in error) and returns the stream state to reset; line_length is kept.
// Throughput: the back-end sequencer gives one output beat per cycle while work is
// queued and the output is not stalled; a data byte gives two characters plus any
// inserted newlines, a header byte none. A two-entry queue decouples the
// header/classify front from the sequencer; the input stalls only while that queue is full.
// Synchronous reset (i_rst_n low) empties the queue and output register and
// sets line_length to 64. A stalled output beat holds; work behind it waits.
// i_cfg_we writes line_length; write only while the block is idle.
`default_nettype none
module calculator_asc_hex_encoder (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [7:0]        i_cfg_wdata,
    input  wire              i_valid,
    output logic             o_stall,
    input  ascx_pkg::t_in    i_data,
    output logic             o_valid,
    input  wire              i_stall,
    output ascx_pkg::t_out   o_data
);
    import ascx_pkg::*;

    t_push q_push;
    t_cmd  q_head;
    logic  q_full, q_empty, q_pop;

    ascx_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_stall  (o_stall),
        .o_push   (q_push)
    );

    ascx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    ascx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push.valid && q_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("pop from empty queue");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_error |-> o_data.last && (o_data.out_char == 8'd0))
        else $error("error beat malformed");

    a_quote_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_data.out_char == CH_QUOTE) && !o_data.is_error
        |=> o_valid && (o_data.out_char == CH_NEWLINE) && o_data.last)
        else $error("quote not followed by closing newline");

endmodule
`default_nettype wire

// File: verif/tb_calculator_asc_hex_encoder.sv
`timescale 1ns / 1ps
module tb_calculator_asc_hex_encoder;
    import ascx_pkg::*;

    // expected header, first byte in the top octet
    localparam logic [63:0] HDR_TEXT = 64'h4850_4850_3438_2D41;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       i_valid;
    logic       o_stall;
    t_in        i_data;
    logic       o_valid;
    logic       i_stall;
    t_out       o_data;

    calculator_asc_hex_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    // encoder model state
    logic [7:0]  line_len;
    logic [7:0]  col;
    logic [15:0] crc;
    logic [3:0]  hdr_pos;
    logic        in_err;

    t_out scratch_q[$];
    t_out char_q[$];

    int errors;
    int beats_sent;
    int src_idle_pct;
    int rx_idle_pct;
    logic rx_hold;

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] hdr_byte(input int k);
        return HDR_TEXT[63 - 8 * k -: 8];
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'd0, n};
        end
        return 8'h41 + {4'd0, n} - 8'd10;
    endfunction

    function automatic void put_char(input logic [7:0] c, input logic e);
        t_out b;
        b.out_char = c;
        b.is_error = e;
        b.last     = 1'b0;
        scratch_q.push_back(b);
    endfunction

    function automatic void put_hex(input logic [3:0] n);
        put_char(hex_ascii(n), 1'b0);
        col = col + 8'd1;
        if (col >= line_len) begin
            put_char(CH_NEWLINE, 1'b0);
            col = 8'd0;
        end
        crc = (crc >> 4) ^ ({12'd0, n ^ crc[3:0]} * CRC_FACTOR);
    endfunction

    function automatic void clear_stream();
        col     = 8'd0;
        crc     = 16'd0;
        hdr_pos = 4'd0;
        in_err  = 1'b0;
    endfunction

    // Works out the characters one accepted beat produces.
    function automatic void encode_beat(input t_in b);
        logic [15:0] sum;
        t_out        r;
        sum = crc;
        scratch_q.delete();
        if (b.action == ACT_CLOSE) begin
            if (in_err) begin
                put_char(8'd0, 1'b1);
            end else begin
                put_hex(sum[3:0]);
                put_hex(sum[7:4]);
                put_hex(sum[11:8]);
                put_hex(sum[15:12]);
                put_char(CH_QUOTE, 1'b0);
                put_char(CH_NEWLINE, 1'b0);
            end
            clear_stream();
        end else if (in_err) begin
            put_char(8'd0, 1'b1);
        end else if (hdr_pos < HDR_LEN) begin
            if (b.data_byte == hdr_byte(int'(hdr_pos[2:0]))) begin
                hdr_pos = hdr_pos + 4'd1;
            end else begin
                in_err = 1'b1;
                put_char(8'd0, 1'b1);
            end
        end else begin
            put_hex(b.data_byte[3:0]);
            put_hex(b.data_byte[7:4]);
        end
        for (int i = 0; i < scratch_q.size(); i++) begin
            r = scratch_q[i];
            r.last = (i == scratch_q.size() - 1);
            char_q.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= 40) begin
            $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        end
    endtask

    task automatic check_beat(input t_out got);
        t_out want;
        if (char_q.size() == 0) begin
            report_mismatch("unexpected beat", got.out_char, 8'd0);
        end else begin
            want = char_q.pop_front();
            if (got.out_char !== want.out_char) begin
                report_mismatch("out_char", got.out_char, want.out_char);
            end
            if (got.is_error !== want.is_error) begin
                report_mismatch("is_error", {7'd0, got.is_error}, {7'd0, want.is_error});
            end
            if (got.last !== want.last) begin
                report_mismatch("last", {7'd0, got.last}, {7'd0, want.last});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_beat(o_data);
        end
        i_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end

    task automatic send_beat(input logic act, input logic [7:0] dbyte);
        t_in b;
        b.action    = act;
        b.data_byte = dbyte;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        encode_beat(b);
        beats_sent++;
    endtask

    task automatic send_header(input int bad_pos);
        logic [7:0] v;
        for (int k = 0; k < 8; k++) begin
            v = hdr_byte(k);
            if (k == bad_pos) begin
                v = v ^ 8'($urandom_range(1, 255));
            end
            send_beat(ACT_DATA, v);
        end
    endtask

    // Drain: header beats give no output, so allow some slack after the last beat.
    task automatic settle();
        i_valid <= 1'b0;
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [7:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        line_len = v;
    endtask

    task automatic hold_receiver(input int n);
        rx_hold <= 1'b1;
        repeat (n) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    function automatic logic [7:0] pick_line_length();
        case ($urandom_range(7))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd1;
            end
            2: begin
                return 8'd2;
            end
            3: begin
                return 8'd3;
            end
            4: begin
                return 8'd64;
            end
            5: begin
                return 8'd255;
            end
            default: begin
                return 8'($urandom_range(4, 40));
            end
        endcase
    endfunction

    task automatic test_basic_stream();
        send_header(-1);
        send_beat(ACT_DATA, 8'h00);
        send_beat(ACT_DATA, 8'hFF);
        send_beat(ACT_CLOSE, 8'h5A);
    endtask

    task automatic test_header_errors();
        // mismatch, then data and close while in error
        send_beat(ACT_DATA, hdr_byte(0));
        send_beat(ACT_DATA, ~hdr_byte(1));
        send_beat(ACT_DATA, 8'hA5);
        send_beat(ACT_CLOSE, 8'h00);
        // close after two header bytes, then close on a fresh stream
        send_beat(ACT_DATA, hdr_byte(0));
        send_beat(ACT_DATA, hdr_byte(1));
        send_beat(ACT_CLOSE, 8'hFF);
        send_beat(ACT_CLOSE, 8'h3C);
    endtask

    task automatic test_random_phase(input int src_pct, input int rx_pct, input int goal);
        int stop_at;
        int n;
        int bad;
        src_idle_pct = src_pct;
        rx_idle_pct  = rx_pct;
        stop_at = beats_sent + goal;
        while (beats_sent < stop_at) begin
            if ($urandom_range(1) == 0) begin
                write_line_length(pick_line_length());
            end
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
                end
            end else begin
                bad = ($urandom_range(99) < 15) ? int'($urandom_range(7)) : -1;
                n = ($urandom_range(9) == 0) ? int'($urandom_range(13, 40))
                                             : int'($urandom_range(0, 12));
                send_header(bad);
                repeat (n) send_beat(ACT_DATA, 8'($urandom_range(255)));
            end
            send_beat(ACT_CLOSE, 8'($urandom_range(255)));
        end
    endtask

    // Long stream at the widest line while the receiver holds off.
    task automatic test_backpressure();
        write_line_length(8'd255);
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        fork
            hold_receiver(300);
        join_none
        send_header(-1);
        repeat (100) send_beat(ACT_DATA, 8'($urandom_range(255)));
        send_beat(ACT_CLOSE, 8'($urandom_range(255)));
    endtask

    initial begin
        i_clk        = 1'b0;
        errors       = 0;
        beats_sent   = 0;
        src_idle_pct = 26;
        rx_idle_pct  = 81;
        line_len     = LINE_LEN_RST;
        clear_stream();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 8'd0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_stall     <= 1'b0;
        rx_hold     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_stream();
        test_header_errors();
        test_random_phase(26, 81, 55);
        test_random_phase(81, 26, 55);
        test_random_phase(0, 0, 55);
        test_backpressure();

        settle();
        repeat (12) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ascx_pkg.sv
rtl/core/ascx_front.sv
rtl/core/ascx_fifo.sv
rtl/core/ascx_back.sv
rtl/core/calculator_asc_hex_encoder.sv
verif/tb_calculator_asc_hex_encoder.sv
